@@ design/exlex_pkg.sv @@
package exlex_pkg;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_expr;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] token_kind;
		logic       token_first;
		logic       token_last;
		logic       run_last;
	} out_item_t;

	// One queue entry carries every result of one input transfer (one or two).
	typedef struct packed {
		logic      has_second;
		out_item_t first_res;
		out_item_t second_res;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [3:0] {
		MODE_NONE   = 4'b0001,
		MODE_NUMBER = 4'b0010,
		MODE_IDENT  = 4'b0100,
		MODE_POWER  = 4'b1000
	} mode_t;

	localparam logic [1:0] KIND_NUMBER = 2'd0;
	localparam logic [1:0] KIND_IDENT  = 2'd1;
	localparam logic [1:0] KIND_POWER  = 2'd2;
	localparam logic [1:0] KIND_SYMBOL = 2'd3;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic      emit;
		out_item_t item;
		mode_t     mode;
		logic      uma;
	} res_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Classify byte c with lookahead n (nv says the lookahead is present).
	function automatic res_t resolve(mode_t mode, logic uma, logic [7:0] c,
			logic nv, logic [7:0] n);
		res_t r;
		logic nd;
		logic na;
		nd = nv && is_digit(n);
		na = nv && (is_digit(n) || is_letter(n));
		r.emit = 1'b1;
		r.mode = mode;
		r.uma = uma;
		r.item.out_char = c;
		r.item.run_last = 1'b0;
		r.item.token_kind = KIND_SYMBOL;
		r.item.token_first = 1'b1;
		r.item.token_last = 1'b1;
		case (mode)
			MODE_POWER: begin
				r.item.token_kind = KIND_POWER;
				r.item.token_first = 1'b0;
				r.mode = MODE_NONE;
			end
			MODE_NUMBER: begin
				r.item.token_kind = KIND_NUMBER;
				r.item.token_first = 1'b0;
				r.item.token_last = !nd;
				if (!nd) r.mode = MODE_NONE;
			end
			MODE_IDENT: begin
				r.item.token_kind = KIND_IDENT;
				r.item.token_first = 1'b0;
				r.item.token_last = !na;
				if (!na) r.mode = MODE_NONE;
			end
			default: begin
				if (is_space(c)) begin
					r.emit = 1'b0;
				end else if (is_digit(c) || ((c == CH_MINUS) && uma && nd)) begin
					r.item.token_kind = KIND_NUMBER;
					r.item.token_last = !nd;
					r.mode = nd ? MODE_NUMBER : MODE_NONE;
					r.uma = 1'b0;
				end else if (is_letter(c)) begin
					r.item.token_kind = KIND_IDENT;
					r.item.token_last = !na;
					r.mode = na ? MODE_IDENT : MODE_NONE;
					r.uma = 1'b0;
				end else if ((c == CH_STAR) && nv && (n == CH_STAR)) begin
					r.item.token_kind = KIND_POWER;
					r.item.token_last = 1'b0;
					r.mode = MODE_POWER;
					r.uma = 1'b1;
				end else begin
					r.mode = MODE_NONE;
					r.uma = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
						(c == CH_SLASH) || (c == CH_LPAREN);
				end
			end
		endcase
		return r;
	endfunction

endpackage

@@ design/exlex_front.sv @@
module exlex_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  exlex_pkg::in_item_t  char_item,
	input  exlex_pkg::q_status_t q_stat,
	output logic                 push,
	output exlex_pkg::q_entry_t  push_entry
);
	import exlex_pkg::*;

	logic [7:0] held_char_q;
	logic       held_valid_q;
	mode_t      mode_q;
	logic       uma_q;

	logic  accept;
	res_t  res_held;
	res_t  res_cur;
	mode_t mode_mid;
	logic  uma_mid;

	assign char_stall = q_stat.full;
	assign accept = char_valid && !q_stat.full;

	always_comb begin
		res_held = resolve(mode_q, uma_q, held_char_q, 1'b1, char_item.in_char);
		if (!held_valid_q) begin
			res_held.emit = 1'b0;
			res_held.mode = mode_q;
			res_held.uma = uma_q;
		end
		mode_mid = res_held.mode;
		uma_mid = res_held.uma;
		// On the final byte there is no lookahead, so it closes any open token.
		res_cur = resolve(mode_mid, uma_mid, char_item.in_char, 1'b0, 8'h00);
		if (!char_item.end_of_expr) res_cur.emit = 1'b0;
	end

	always_comb begin
		push = accept && (res_held.emit || res_cur.emit);
		push_entry.has_second = res_held.emit && res_cur.emit;
		push_entry.first_res = res_held.emit ? res_held.item : res_cur.item;
		push_entry.first_res.run_last = !(res_held.emit && res_cur.emit);
		push_entry.second_res = res_cur.item;
		push_entry.second_res.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q <= 8'h00;
			held_valid_q <= 1'b0;
			mode_q <= MODE_NONE;
			uma_q <= 1'b1;
		end else if (accept) begin
			if (char_item.end_of_expr) begin
				held_char_q <= 8'h00;
				held_valid_q <= 1'b0;
				mode_q <= MODE_NONE;
				uma_q <= 1'b1;
			end else begin
				held_char_q <= char_item.in_char;
				held_valid_q <= 1'b1;
				mode_q <= mode_mid;
				uma_q <= uma_mid;
			end
		end
	end

endmodule

@@ design/exlex_queue.sv @@
module exlex_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  exlex_pkg::q_entry_t  push_entry,
	input  logic                 pop,
	output exlex_pkg::q_entry_t  head,
	output exlex_pkg::q_status_t q_stat
);
	import exlex_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	q_entry_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full = (count_q == FULL_COUNT);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push) else $error("push into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop) else $error("pop from an empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

@@ design/exlex_back.sv @@
module exlex_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  exlex_pkg::q_entry_t  head,
	input  exlex_pkg::q_status_t q_stat,
	output logic                 pop,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output exlex_pkg::out_item_t tok_item
);
	import exlex_pkg::*;

	logic      out_valid_q;
	out_item_t out_q;
	logic      second_q;
	logic      load;

	// The output register takes a new result when it is empty or being drained.
	assign load = !q_stat.empty && (!out_valid_q || !tok_stall);
	assign pop = load && (!head.has_second || second_q);

	assign tok_valid = out_valid_q;
	assign tok_item = out_q;

	always_ff @(posedge clk) begin
		if (load) out_q <= second_q ? head.second_res : head.first_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!tok_stall) out_valid_q <= 1'b0;
			if (load) second_q <= head.has_second && !second_q;
		end
	end

endmodule

@@ design/expression_lexer.sv @@
// Streaming lexer for arithmetic expression text.
// Input channel char_*: one byte per transfer, end_of_expr set on the last
// byte of an expression. Output channel tok_*: one token character per
// transfer, tagged with its kind (number, identifier, power, symbol), first
// and last marks, and run_last on the final result caused by an input byte.
// A byte is held back as lookahead and is classified when the next byte
// arrives, so its result leaves with the following transfer; the final byte
// of an expression releases both the held byte and itself. Whitespace gives
// no result. Tokens may be of any length.
// A result released by a transfer is written into the queue, then loaded into
// the output register that drives tok_*. Throughput: one byte per cycle while
// char_stall is low; the output side drains one result per cycle while
// tok_stall is low, so the final byte, which may release two results, needs
// two output transfers to drain. A queue of QUEUE_DEPTH entries sits between
// the classifier and the output register. Reset clears the lookahead, the open
// token and the queue; tok_valid drops. While tok_stall is high the shown
// result holds, the queue fills, and char_stall rises once it is full.
module expression_lexer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  exlex_pkg::in_item_t  char_item,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output exlex_pkg::out_item_t tok_item
);
	import exlex_pkg::*;

	q_status_t q_stat;
	logic      push;
	logic      pop;
	q_entry_t  push_entry;
	q_entry_t  head;

	exlex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	exlex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	exlex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule

@@ tb/expression_lexer_tb.sv @@
module expression_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import exlex_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	in_item_t  char_item;
	logic      tok_valid;
	logic      tok_stall;
	out_item_t tok_item;

	expression_lexer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item (char_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	// Lexer state as predicted from the transfers seen on the input side.
	logic [7:0] look_char;
	logic       look_valid;
	mode_t      open_mode;
	logic       minus_ok;
	out_item_t  expected_tokens[$];

	logic [7:0] expr_buf[$];
	int         n_bytes;
	int         n_exprs;
	int         n_tokens;
	int         n_errors;
	int         hold_len;
	logic       tx_idle_en;
	logic       rx_idle_en;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	function automatic logic chr_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic chr_alnum(logic [7:0] c);
		return chr_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void lex_clear();
		look_char = 8'h00;
		look_valid = 1'b0;
		open_mode = MODE_NONE;
		minus_ok = 1'b1;
	endfunction

	// Classifies byte c against lookahead n and updates the open token.
	function automatic void lex_classify(input logic [7:0] c, input logic nv,
			input logic [7:0] n, output logic emit, output out_item_t t);
		logic nd;
		logic na;
		nd = nv && chr_digit(n);
		na = nv && chr_alnum(n);
		emit = 1'b1;
		t = '{out_char: c, token_kind: KIND_SYMBOL, token_first: 1'b1,
			token_last: 1'b1, run_last: 1'b0};
		if (open_mode == MODE_POWER) begin
			t.token_kind = KIND_POWER;
			t.token_first = 1'b0;
			open_mode = MODE_NONE;
		end else if (open_mode == MODE_NUMBER) begin
			t.token_kind = KIND_NUMBER;
			t.token_first = 1'b0;
			t.token_last = !nd;
			if (!nd) open_mode = MODE_NONE;
		end else if (open_mode == MODE_IDENT) begin
			t.token_kind = KIND_IDENT;
			t.token_first = 1'b0;
			t.token_last = !na;
			if (!na) open_mode = MODE_NONE;
		end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
			emit = 1'b0;
		end else if (chr_digit(c) || (c == CH_MINUS && minus_ok && nd)) begin
			t.token_kind = KIND_NUMBER;
			t.token_last = !nd;
			open_mode = nd ? MODE_NUMBER : MODE_NONE;
			minus_ok = 1'b0;
		end else if (chr_alnum(c)) begin
			t.token_kind = KIND_IDENT;
			t.token_last = !na;
			open_mode = na ? MODE_IDENT : MODE_NONE;
			minus_ok = 1'b0;
		end else if (c == CH_STAR && nv && n == CH_STAR) begin
			t.token_kind = KIND_POWER;
			t.token_last = 1'b0;
			open_mode = MODE_POWER;
			minus_ok = 1'b1;
		end else begin
			minus_ok = c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
				c == CH_SLASH || c == CH_LPAREN;
		end
	endfunction

	function automatic void lex_accept(logic [7:0] c, logic eoe);
		out_item_t res[2];
		out_item_t t;
		logic emit;
		int cnt;
		cnt = 0;
		if (look_valid) begin
			lex_classify(look_char, 1'b1, c, emit, t);
			if (emit) begin
				res[cnt] = t;
				cnt++;
			end
		end
		if (eoe) begin
			lex_classify(c, 1'b0, 8'h00, emit, t);
			if (emit) begin
				res[cnt] = t;
				cnt++;
			end
			lex_clear();
		end else begin
			look_char = c;
			look_valid = 1'b1;
		end
		if (cnt > 0) res[cnt - 1].run_last = 1'b1;
		for (int i = 0; i < cnt; i++) expected_tokens.push_back(res[i]);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) lex_accept(char_item.in_char,
			char_item.end_of_expr);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token character %0d", tok_item.out_char);
				n_errors++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("out_char", want.out_char, tok_item.out_char);
				check_field("token_kind", 8'(want.token_kind), 8'(tok_item.token_kind));
				check_field("token_first", 8'(want.token_first), 8'(tok_item.token_first));
				check_field("token_last", 8'(want.token_last), 8'(tok_item.token_last));
				check_field("run_last", 8'(want.run_last), 8'(tok_item.run_last));
				n_tokens++;
			end
		end
	end

	// Output side: random stall bursts, or one long hold-off when requested.
	initial begin
		int n;
		tok_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 10);
			end else begin
				n = 0;
			end
			tok_stall <= (n != 0);
			if (n > 1) repeat (n - 1) @(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic eoe);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			char_valid <= 1'b0;
			if (gap > 1) repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		char_valid <= 1'b1;
		char_item <= '{in_char: c, end_of_expr: eoe};
		do @(posedge clk); while (char_stall);
		n_bytes++;
	endtask

	task automatic send_expr();
		for (int i = 0; i < expr_buf.size(); i++)
			send_byte(expr_buf[i], i == expr_buf.size() - 1);
		n_exprs++;
	endtask

	task automatic send_text(input string s);
		expr_buf.delete();
		for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
		send_expr();
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) :
			8'($urandom_range("a", "z"));
	endfunction

	// Mostly well-formed expressions; some are broken by a stray byte or are
	// pure noise. A few tokens run well past 31 characters.
	task automatic build_expr();
		int ntok;
		int len;
		expr_buf.delete();
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6)) expr_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		ntok = $urandom_range(1, 8);
		repeat (ntok) begin
			len = ($urandom_range(0, 29) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 2) == 0) expr_buf.push_back(CH_MINUS);
					repeat (len) expr_buf.push_back(8'($urandom_range("0", "9")));
				end
				2: begin
					expr_buf.push_back(rand_letter());
					repeat (len - 1)
						expr_buf.push_back($urandom_range(0, 2) == 0 ?
							8'($urandom_range("0", "9")) : rand_letter());
				end
				3, 4: begin
					case ($urandom_range(0, 3))
						0: expr_buf.push_back(CH_PLUS);
						1: expr_buf.push_back(CH_MINUS);
						2: expr_buf.push_back(CH_STAR);
						default: expr_buf.push_back(CH_SLASH);
					endcase
				end
				5: begin
					expr_buf.push_back(CH_STAR);
					expr_buf.push_back(CH_STAR);
				end
				6: expr_buf.push_back($urandom_range(0, 1) ? CH_LPAREN : 8'h29);
				7: expr_buf.push_back($urandom_range(0, 1) ? CH_SPACE :
					8'($urandom_range(9, 13)));
				8: begin
					expr_buf.push_back(CH_MINUS);
					expr_buf.push_back(8'($urandom_range("0", "9")));
				end
				default: expr_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic test_directed();
		send_text("7");
		send_text(" ");
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_text("-5");
		send_text("3-4");
		send_text("a**-2");
		send_text("x*y");
		send_text("- 3");
		send_text("(-9");
		send_text("\tZ");
	endtask

	// The output side holds off while input keeps coming, so the internal
	// queue fills and the input side must stall.
	task automatic test_backpressure();
		int start;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_len = 150;
		start = n_bytes;
		while (n_bytes - start < 40) begin
			build_expr();
			send_expr();
		end
	endtask

	task automatic test_random(input int count);
		int start;
		start = n_bytes;
		while (n_bytes - start < count) begin
			build_expr();
			send_expr();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_item = '0;
		hold_len = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		n_bytes = 0;
		n_exprs = 0;
		n_tokens = 0;
		n_errors = 0;
		lex_clear();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_random(500);
		// Final stretch at full rate on both sides.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random(100);

		@(negedge clk);
		char_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d expressions; %0d token characters compared.",
			n_bytes, n_exprs, n_tokens);
		$display("Covered unary minus, power operator, long tokens, noise bytes and stalls.");
		if (n_errors == 0) begin
			$display("expression_lexer: match");
		end else begin
			$display("expression_lexer: mismatch");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timed out with %0d results still expected.", expected_tokens.size());
		$display("expression_lexer: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
design/exlex_pkg.sv
design/exlex_front.sv
design/exlex_queue.sv
design/exlex_back.sv
design/expression_lexer.sv
tb/expression_lexer_tb.sv
